[sv/pip_pkg.sv]
// Shared types and codes for the point-in-polygon test block.
// No dependencies; every other file refers to this package by scoped names.
package pip_pkg;

  // Item modes; the fourth code is unused and leaves the store untouched.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } pip_mode_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_CLOSE = 4'b0100,
    ST_DRAIN = 4'b1000
  } pip_state_t;

  // Width of the reported vertex total.
  localparam int TOTAL_W = 7;

  // Per-cell control of the vertex ring.
  typedef struct packed {
    logic load;   // take the appended vertex
    logic shift;  // take the neighbour's vertex
    logic wrap;   // this cell holds the last vertex: take cell 0 instead
  } pip_cell_ctl_t;

  // Status of the edge test pipeline.
  typedef struct packed {
    logic busy;    // an edge is still in flight
    logic toggle;  // the edge leaving the pipeline crosses: flip parity
  } pip_edge_sts_t;

endpackage

[sv/pip_vcell.sv]
// One cell of the vertex ring: holds one vertex and passes it to its neighbour.
// Depends on pip_pkg for the cell control struct.
module pip_vcell #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  pip_pkg::pip_cell_ctl_t       ctl,
  input  logic signed [COORD_BITS-1:0] load_x,
  input  logic signed [COORD_BITS-1:0] load_y,
  input  logic signed [COORD_BITS-1:0] next_x,
  input  logic signed [COORD_BITS-1:0] next_y,
  input  logic signed [COORD_BITS-1:0] ring_x,
  input  logic signed [COORD_BITS-1:0] ring_y,
  output logic signed [COORD_BITS-1:0] q_x,
  output logic signed [COORD_BITS-1:0] q_y
);

  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic signed [COORD_BITS-1:0] x_nxt, y_nxt;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctl.load) begin
      x_nxt = load_x;
      y_nxt = load_y;
    end else if (ctl.shift) begin
      x_nxt = ctl.wrap ? ring_x : next_x;
      y_nxt = ctl.wrap ? ring_y : next_y;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign q_x = x_r;
  assign q_y = y_r;

endmodule

[sv/pip_edge.sv]
// Three-stage edge crossing test: straddle check, cross products, sign compare.
// Depends on pip_pkg for the status struct.
module pip_edge #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         edge_vld,
  input  logic signed [COORD_BITS-1:0] xi,
  input  logic signed [COORD_BITS-1:0] yi,
  input  logic signed [COORD_BITS-1:0] xj,
  input  logic signed [COORD_BITS-1:0] yj,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output pip_pkg::pip_edge_sts_t       sts
);

  localparam int D_W = COORD_BITS + 1;
  localparam int P_W = 2 * D_W;

  logic             v1_r, v2_r, v3_r;
  logic             strad1_r, strad2_r;
  logic             dyneg1_r, dyneg2_r;
  logic             tog3_r;
  logic signed [D_W-1:0] a_r, dy_r, b_r, c_r;
  logic signed [D_W-1:0] a_nxt, dy_nxt, b_nxt, c_nxt;
  logic signed [P_W-1:0] p1_r, p2_r;
  logic signed [P_W:0]   diff;
  logic                  strad_nxt, left;

  // Stage 1: differences and straddle test.
  always_comb begin
    a_nxt     = D_W'(px) - D_W'(xi);
    dy_nxt    = D_W'(yj) - D_W'(yi);
    b_nxt     = D_W'(xj) - D_W'(xi);
    c_nxt     = D_W'(py) - D_W'(yi);
    strad_nxt = (yi > py) != (yj > py);
  end

  // Stage 3: point is left of the crossing when the difference opposes dy.
  always_comb begin
    diff = (P_W+1)'(p1_r) - (P_W+1)'(p2_r);
    left = dyneg2_r ? (diff > 0) : (diff < 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      tog3_r <= 1'b0;
    end else begin
      v1_r   <= edge_vld;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      tog3_r <= v2_r & strad2_r & left;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    dy_r     <= dy_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    strad1_r <= strad_nxt;
    dyneg1_r <= dy_nxt[D_W-1];
    p1_r     <= P_W'(a_r) * P_W'(dy_r);
    p2_r     <= P_W'(b_r) * P_W'(c_r);
    strad2_r <= strad1_r;
    dyneg2_r <= dyneg1_r;
  end

  assign sts.busy   = v1_r | v2_r | v3_r;
  assign sts.toggle = tog3_r;

endmodule

[sv/point_in_polygon_test.sv]
// Top level of the even-odd point-in-polygon test.
// Depends on pip_pkg, pip_vcell (vertex ring) and pip_edge (crossing test).
//
// Each transfer (start high while busy is low) carries a mode and a point.
// Clear and append finish at once: their result strobes out_valid in the next
// cycle and busy never rises, so such items may follow back to back. A query
// raises busy and walks the polygon by rotating the ring of vertex cells one
// place per cycle, feeding one edge per cycle into a three-stage crossing
// test; the closing edge from the first to the last vertex follows, then the
// pipeline drains. The result is registered once the drain ends, and busy
// falls as it appears; the ring walk takes one step per stored vertex. A query
// on an empty polygon answers at once. Each result is shown for exactly one
// cycle and the receiver cannot hold it off. Mode 3 is ignored and reports
// the current vertex total.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                         out_valid,
  output logic                         out_inside_res,
  output logic [pip_pkg::TOTAL_W-1:0]  out_vertex_total,
  output logic                         out_dropped
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  pip_pkg::pip_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             parity_r, parity_nxt;
  logic             accept, full, do_append;

  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;

  logic signed [COORD_BITS-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cell_y [MAX_VERTICES];

  logic                edge_vld;
  pip_pkg::pip_edge_sts_t edge_sts;

  logic                        emit;
  logic                        emit_inside, emit_dropped;
  logic                        out_valid_r;
  logic                        out_inside_r, out_dropped_r;
  logic [pip_pkg::TOTAL_W-1:0] out_total_r;

  assign accept    = start & (state_r == pip_pkg::ST_IDLE);
  assign full      = (count_r == CNT_W'(MAX_VERTICES));
  assign do_append = accept & (in_mode == pip_pkg::MODE_APPEND) & ~full;

  // Vertex ring: cell k holds vertex k between queries.
  for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_cell
    pip_pkg::pip_cell_ctl_t ctl;
    logic signed [COORD_BITS-1:0] nx, ny;

    assign ctl.load  = do_append & (count_r == CNT_W'(gi));
    assign ctl.shift = (state_r == pip_pkg::ST_WALK);
    // the last stored vertex closes the ring back onto cell 0
    assign ctl.wrap  = ((CNT_W'(gi) + CNT_W'(1)) == count_r);

    if (gi == MAX_VERTICES - 1) begin : g_last
      assign nx = cell_x[0];
      assign ny = cell_y[0];
    end else begin : g_mid
      assign nx = cell_x[gi+1];
      assign ny = cell_y[gi+1];
    end

    pip_vcell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .load_x (in_coord_x),
      .load_y (in_coord_y),
      .next_x (nx),
      .next_y (ny),
      .ring_x (cell_x[0]),
      .ring_y (cell_y[0]),
      .q_x    (cell_x[gi]),
      .q_y    (cell_y[gi])
    );
  end

  // Edge feed: vertex k with vertex k-1 while walking, then first with last.
  always_comb begin
    if (state_r == pip_pkg::ST_CLOSE) begin
      cur_x = first_x_r;
      cur_y = first_y_r;
    end else begin
      cur_x = cell_x[0];
      cur_y = cell_y[0];
    end
    edge_vld = (state_r == pip_pkg::ST_CLOSE) ||
               ((state_r == pip_pkg::ST_WALK) && (step_r != '0));
  end

  pip_edge #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .edge_vld (edge_vld),
    .xi       (cur_x),
    .yi       (cur_y),
    .xj       (prev_x_r),
    .yj       (prev_y_r),
    .px       (px_r),
    .py       (py_r),
    .sts      (edge_sts)
  );

  // Sequencer and result selection.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    step_nxt     = step_r;
    parity_nxt   = parity_r ^ edge_sts.toggle;
    emit         = 1'b0;
    emit_inside  = 1'b0;
    emit_dropped = 1'b0;
    case (state_r)
      pip_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            pip_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              emit      = 1'b1;
            end
            pip_pkg::MODE_APPEND: begin
              if (full) begin
                emit_dropped = 1'b1;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
              emit = 1'b1;
            end
            pip_pkg::MODE_QUERY: begin
              parity_nxt = 1'b0;
              step_nxt   = '0;
              if (count_r == '0) begin
                emit = 1'b1;
              end else begin
                state_nxt = pip_pkg::ST_WALK;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      pip_pkg::ST_WALK: begin
        step_nxt = step_r + CNT_W'(1);
        if (step_r == count_r - CNT_W'(1)) begin
          state_nxt = pip_pkg::ST_CLOSE;
        end
      end
      pip_pkg::ST_CLOSE: begin
        state_nxt = pip_pkg::ST_DRAIN;
      end
      pip_pkg::ST_DRAIN: begin
        // hold until the last toggle has left the pipeline
        if (!edge_sts.busy) begin
          emit        = 1'b1;
          emit_inside = parity_r;
          state_nxt   = pip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pip_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pip_pkg::ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= emit;
    end
  end

  // Payload registers: query point, first vertex, previous vertex, result.
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_coord_x;
      py_r <= in_coord_y;
    end
    if ((state_r == pip_pkg::ST_WALK) && (step_r == '0)) begin
      first_x_r <= cell_x[0];
      first_y_r <= cell_y[0];
    end
    if (state_r == pip_pkg::ST_WALK) begin
      prev_x_r <= cell_x[0];
      prev_y_r <= cell_y[0];
    end
    if (emit) begin
      out_inside_r  <= emit_inside;
      out_dropped_r <= emit_dropped;
      out_total_r   <= pip_pkg::TOTAL_W'(count_nxt);
    end
  end

  assign busy             = (state_r != pip_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_inside_res   = out_inside_r;
  assign out_dropped      = out_dropped_r;
  assign out_vertex_total = out_total_r;

endmodule

[sv/pip_chk.sv]
// Port-level checks for the point-in-polygon test, bound to the top level.
// Depends on pip_pkg for the mode codes.
module pip_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_inside_res,
  input logic [6:0] out_vertex_total,
  input logic       out_dropped
);

  logic xfer;
  assign xfer = start & ~busy;

  // Non-query items answer in the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && (in_mode != pip_pkg::MODE_QUERY) |=> out_valid)
    else $error("non-query transfer gave no result in the next cycle");

  // A clear leaves an empty store.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && (in_mode == pip_pkg::MODE_CLEAR) |=> (out_vertex_total == 7'd0))
    else $error("clear did not report an empty store");

  // A query either starts walking or answers at once.
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && (in_mode == pip_pkg::MODE_QUERY) |=> (busy || out_valid))
    else $error("query transfer neither ran nor answered");

  // The end of a query walk delivers its result.
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  // Dropped and inside are never reported together.
  a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_dropped && out_inside_res))
    else $error("dropped and inside both set");

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_inside_res   (out_inside_res),
  .out_vertex_total (out_vertex_total),
  .out_dropped      (out_dropped)
);
